// ----- hdl/cpt_pkg.sv -----
// shared types, constants and sine rom content for the clarke/park transform unit
`default_nettype none

package cpt_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int ANGLE_W         = 16;
    localparam int FRAC_BITS       = 15;
    localparam int COEF_W          = FRAC_BITS + 2;
    localparam int PROD_W          = DATA_WIDTH + COEF_W;
    localparam int SUM_W           = PROD_W + 1;
    localparam int RND_W           = SUM_W - FRAC_BITS;
    localparam int ROM_AW          = SINE_TABLE_BITS + 1;
    localparam int ROM_DEPTH       = (1 << SINE_TABLE_BITS) + 1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic        [ANGLE_W-1:0]    angle_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [RND_W-1:0]      rnd_t;
    typedef logic        [FRAC_BITS-1:0]  sine_mag_t;
    typedef logic        [ROM_AW-1:0]     rom_addr_t;
    typedef sine_mag_t sine_rom_t [ROM_DEPTH];

    typedef enum logic [1:0] {
        FUNC_CLARKE     = 2'd0,
        FUNC_INV_CLARKE = 2'd1,
        FUNC_PARK       = 2'd2,
        FUNC_INV_PARK   = 2'd3
    } func_t;

    // q15 coefficients: one, 2/sqrt(3), 1/sqrt(3), sqrt(3)/2, minus one half
    localparam coef_t K_ONE        = coef_t'(1 << FRAC_BITS);
    localparam coef_t K_INV_SQRT3  = coef_t'(18919);
    localparam coef_t K_TWO_SQRT3  = coef_t'(2 * 18919);
    localparam coef_t K_HALF_SQRT3 = coef_t'(28378);
    localparam coef_t K_NEG_HALF   = coef_t'(-16384);
    localparam coef_t K_ZERO       = coef_t'(0);

    localparam rom_addr_t ROM_LAST = rom_addr_t'(1 << SINE_TABLE_BITS);
    localparam sum_t      HALF_LSB = sum_t'(1 << (FRAC_BITS - 1));

    typedef struct packed {
        logic      valid;
        func_t     func;
        data_t     a;
        data_t     b;
        sine_mag_t sin_mag;
        logic      sin_neg;
        sine_mag_t cos_mag;
        logic      cos_neg;
    } rom_stage_t;

    typedef struct packed {
        logic  valid;
        func_t func;
        prod_t pa0;
        prod_t pa1;
        prod_t pb0;
        prod_t pb1;
    } mult_stage_t;

    // signed q30 multiply with round half up on the magnitude
    function automatic longint mul_q30(input longint x, input longint y);
        logic                neg;
        longint unsigned     ux;
        longint unsigned     uy;
        longint unsigned     p;
        neg = (x < 0) != (y < 0);
        ux  = (x < 0) ? longint'(-x) : x;
        uy  = (y < 0) ? longint'(-y) : y;
        p   = (ux * uy + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // quarter-wave sine, odd taylor series to degree 11 in q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    coef [6];
        longint    x;
        longint    u;
        longint    p;
        longint    s;
        longint    e;
        coef[0] = 64'd1686629713;
        coef[1] = 64'd693598668;
        coef[2] = 64'd85569306;
        coef[3] = 64'd5026995;
        coef[4] = 64'd172272;
        coef[5] = 64'd3864;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x = (longint'(i) << 30) >> SINE_TABLE_BITS;
            u = mul_q30(x, x);
            p = coef[5];
            for (int k = 4; k >= 0; k--)
            begin
                p = coef[k] - mul_q30(u, p);
            end
            s = mul_q30(x, p);
            if (s < 0)
            begin
                s = 0;
            end
            e = (s * 32767 + (64'd1 << 29)) >>> 30;
            if (e > 32767)
            begin
                e = 32767;
            end
            rom[i] = sine_mag_t'(e);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- hdl/cpt_ifs.sv -----
// request and response channel interfaces of the transform unit
`default_nettype none

interface cpt_req_if import cpt_pkg::*; ();
    logic   valid;
    logic   ready;
    func_t  func;
    data_t  in_a;
    data_t  in_b;
    angle_t angle;

    modport source (output valid, output func, output in_a, output in_b, output angle,
                    input ready);
    modport sink   (input valid, input func, input in_a, input in_b, input angle,
                    output ready);
endinterface

interface cpt_rsp_if import cpt_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t out_a;
    data_t out_b;
    data_t out_c;
    logic  saturated;

    modport source (output valid, output out_a, output out_b, output out_c,
                    output saturated, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c,
                    input saturated, output ready);
endinterface

`default_nettype wire

// ----- hdl/cpt_sincos_rom.sv -----
// input register stage with quarter-wave sine and cosine rom lookup
`default_nettype none

module cpt_sincos_rom import cpt_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    cpt_req_if.sink    req,
    output rom_stage_t stage
);

    logic                          valid_reg;
    func_t                         func_reg;
    data_t                         a_reg;
    data_t                         b_reg;
    sine_mag_t                     sin_mag_reg;
    sine_mag_t                     cos_mag_reg;
    logic                          sin_neg_reg;
    logic                          cos_neg_reg;
    logic [1:0]                    quad;
    logic [1:0]                    cos_quad;
    logic [SINE_TABLE_BITS-1:0]    idx;
    rom_addr_t                     idx_ext;
    rom_addr_t                     sin_addr;
    rom_addr_t                     cos_addr;

    assign req.ready = advance;

    assign quad     = req.angle[ANGLE_W-1 -: 2];
    assign cos_quad = quad + 2'd1;
    assign idx      = req.angle[ANGLE_W-3 -: SINE_TABLE_BITS];
    assign idx_ext  = {1'b0, idx};
    assign sin_addr = quad[0]     ? ROM_LAST - idx_ext : idx_ext;
    assign cos_addr = cos_quad[0] ? ROM_LAST - idx_ext : idx_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            func_reg    <= req.func;
            a_reg       <= req.in_a;
            b_reg       <= req.in_b;
            sin_mag_reg <= SINE_ROM[sin_addr];
            cos_mag_reg <= SINE_ROM[cos_addr];
            sin_neg_reg <= quad[1];
            cos_neg_reg <= cos_quad[1];
        end
    end

    assign stage = '{valid:   valid_reg,
                     func:    func_reg,
                     a:       a_reg,
                     b:       b_reg,
                     sin_mag: sin_mag_reg,
                     sin_neg: sin_neg_reg,
                     cos_mag: cos_mag_reg,
                     cos_neg: cos_neg_reg};

endmodule

`default_nettype wire

// ----- hdl/cpt_mult_stage.sv -----
// coefficient selection and the four registered products
`default_nettype none

module cpt_mult_stage import cpt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire rom_stage_t rom_stage,
    output mult_stage_t stage
);

    logic  valid_reg;
    func_t func_reg;
    prod_t pa0_reg;
    prod_t pa1_reg;
    prod_t pb0_reg;
    prod_t pb1_reg;
    coef_t sin_c;
    coef_t cos_c;
    coef_t ca0;
    coef_t ca1;
    coef_t cb0;
    coef_t cb1;

    assign sin_c = rom_stage.sin_neg ? -coef_t'({2'b00, rom_stage.sin_mag})
                                     :  coef_t'({2'b00, rom_stage.sin_mag});
    assign cos_c = rom_stage.cos_neg ? -coef_t'({2'b00, rom_stage.cos_mag})
                                     :  coef_t'({2'b00, rom_stage.cos_mag});

    always_comb
    begin
        unique case (rom_stage.func)
            FUNC_CLARKE:
            begin
                ca0 = K_ONE;
                ca1 = K_ZERO;
                cb0 = K_INV_SQRT3;
                cb1 = K_TWO_SQRT3;
            end
            FUNC_INV_CLARKE:
            begin
                ca0 = K_ONE;
                ca1 = K_ZERO;
                cb0 = K_NEG_HALF;
                cb1 = K_HALF_SQRT3;
            end
            FUNC_PARK:
            begin
                ca0 = cos_c;
                ca1 = sin_c;
                cb0 = -sin_c;
                cb1 = cos_c;
            end
            default:
            begin
                ca0 = cos_c;
                ca1 = -sin_c;
                cb0 = sin_c;
                cb1 = cos_c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= rom_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            func_reg <= rom_stage.func;
            pa0_reg  <= prod_t'(rom_stage.a) * prod_t'(ca0);
            pa1_reg  <= prod_t'(rom_stage.b) * prod_t'(ca1);
            pb0_reg  <= prod_t'(rom_stage.a) * prod_t'(cb0);
            pb1_reg  <= prod_t'(rom_stage.b) * prod_t'(cb1);
        end
    end

    assign stage = '{valid: valid_reg,
                     func:  func_reg,
                     pa0:   pa0_reg,
                     pa1:   pa1_reg,
                     pb0:   pb0_reg,
                     pb1:   pb1_reg};

endmodule

`default_nettype wire

// ----- hdl/cpt_sat_stage.sv -----
// product sums, round half up, saturation and the output register
`default_nettype none

module cpt_sat_stage import cpt_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire mult_stage_t mult_stage,
    output logic       advance,
    cpt_rsp_if.source  rsp
);

    logic  valid_reg;
    data_t out_a_reg;
    data_t out_b_reg;
    data_t out_c_reg;
    logic  sat_reg;
    sum_t  sum_a;
    sum_t  sum_b;
    sum_t  sum_c;
    logic [DATA_WIDTH:0] res_a;
    logic [DATA_WIDTH:0] res_b;
    logic [DATA_WIDTH:0] res_c;
    logic  use_c;

    // returns {clipped, value}
    function automatic logic [DATA_WIDTH:0] round_sat(input sum_t v);
        sum_t  t;
        rnd_t  r;
        rnd_t  hi;
        rnd_t  lo;
        data_t q;
        logic  f;
        hi = {{(RND_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        lo = {{(RND_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
        t  = v + HALF_LSB;
        r  = t[SUM_W-1:FRAC_BITS];
        f  = 1'b0;
        if (r > hi)
        begin
            r = hi;
            f = 1'b1;
        end
        else if (r < lo)
        begin
            r = lo;
            f = 1'b1;
        end
        q = r[DATA_WIDTH-1:0];
        return {f, q};
    endfunction

    assign advance = !valid_reg || rsp.ready;

    assign sum_a = sum_t'(mult_stage.pa0) + sum_t'(mult_stage.pa1);
    assign sum_b = sum_t'(mult_stage.pb0) + sum_t'(mult_stage.pb1);
    assign sum_c = sum_t'(mult_stage.pb0) - sum_t'(mult_stage.pb1);
    assign res_a = round_sat(sum_a);
    assign res_b = round_sat(sum_b);
    assign res_c = round_sat(sum_c);
    assign use_c = (mult_stage.func == FUNC_INV_CLARKE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= mult_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_a_reg <= res_a[DATA_WIDTH-1:0];
            out_b_reg <= res_b[DATA_WIDTH-1:0];
            out_c_reg <= use_c ? res_c[DATA_WIDTH-1:0] : '0;
            sat_reg   <= res_a[DATA_WIDTH] | res_b[DATA_WIDTH] | (use_c & res_c[DATA_WIDTH]);
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.out_a     = out_a_reg;
    assign rsp.out_b     = out_b_reg;
    assign rsp.out_c     = out_c_reg;
    assign rsp.saturated = sat_reg;

endmodule

`default_nettype wire

// ----- hdl/clarke_park_transform_unit.sv -----
// top level of the clarke/park transform unit
// Each request word selects Clarke, inverse Clarke, Park or inverse Park on Q1.15
// operands; the angle is a turn fraction looked up in a quarter-wave sine rom of
// 1025 entries (the angle bits below the rom index are dropped). Results are rounded
// half up and clipped to Q1.15, with saturated set on any clip; out_c is zero except
// for inverse Clarke. The unit is a three-register pipeline: rom read register,
// multiplier register, output register. It accepts one word every cycle; the accepting
// edge loads the rom read register, and the word then moves on through the multiplier
// register to the output register, from which it leaves when the sink is ready; when
// the output is held by the sink, the whole pipeline stalls and ready drops.
`default_nettype none

module clarke_park_transform_unit import cpt_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    cpt_req_if.sink   req,
    cpt_rsp_if.source rsp
);

    logic        advance;
    rom_stage_t  rom_stage;
    mult_stage_t mult_stage;

    cpt_sincos_rom u_sincos_rom (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req       (req),
        .stage     (rom_stage)
    );

    cpt_mult_stage u_mult_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rom_stage (rom_stage),
        .stage     (mult_stage)
    );

    cpt_sat_stage u_sat_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .mult_stage (mult_stage),
        .advance    (advance),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- bench/tb_clarke_park_transform_unit.sv -----
// self-checking testbench for the clarke/park transform unit
`timescale 1ns / 1ps

module tb_clarke_park_transform_unit;
    import cpt_pkg::*;

    typedef struct packed {
        data_t a;
        data_t b;
        data_t c;
        logic  sat;
    } xform_res_t;

    typedef struct packed {
        func_t      func;
        data_t      a;
        data_t      b;
        angle_t     angle;
        logic       known;
        xform_res_t fixed;
    } xform_req_t;

    localparam int     TABLE_LAST       = 1 << SINE_TABLE_BITS;
    localparam int     RANDOM_PER_PHASE = 276;
    localparam int     HOLD_AT          = 131;
    localparam int     CYCLE_LIMIT      = 200_000;
    localparam longint INV_SQRT3_Q15    = 18919;
    localparam longint HALF_SQRT3_Q15   = 28378;
    localparam longint HALF_Q15         = 16384;
    localparam longint Q15_MAX          = 32767;
    localparam longint Q15_MIN          = -32768;
    localparam longint TAYLOR_Q30 [6]   = '{1686629713, 693598668, 85569306,
                                            5026995, 172272, 3864};
    localparam int     SRC_IDLE [3]     = '{18, 77, 0};
    localparam int     SNK_IDLE [3]     = '{77, 18, 0};

    localparam int N_DIRECTED = 22;
    localparam xform_req_t DIRECTED [N_DIRECTED] = '{
        '{FUNC_CLARKE,     0,      0,      16'h0000, 1, '{0, 0, 0, 0}},
        '{FUNC_CLARKE,     32767,  32767,  16'h0000, 1, '{32767, 32767, 0, 1}},
        '{FUNC_CLARKE,     -32768, -32768, 16'h0000, 1, '{-32768, -32768, 0, 1}},
        '{FUNC_CLARKE,     -32768, 16384,  16'hFFFF, 1, '{-32768, 0, 0, 0}},
        '{FUNC_CLARKE,     1234,   -567,   16'h1357, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_CLARKE, 0,      0,      16'h0000, 1, '{0, 0, 0, 0}},
        '{FUNC_INV_CLARKE, -32768, -32768, 16'h0000, 1, '{-32768, -11994, 32767, 1}},
        '{FUNC_INV_CLARKE, 32767,  32767,  16'h8000, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_CLARKE, -32768, 32767,  16'h4000, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       0,      0,      16'h1234, 1, '{0, 0, 0, 0}},
        '{FUNC_PARK,       32767,  0,      16'h0000, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       -32768, -32768, 16'h2000, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       32767,  -32768, 16'h4000, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       1000,   2000,   16'h800F, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       1000,   2000,   16'h8000, 0, '{0, 0, 0, 0}},
        '{FUNC_PARK,       -1,     -1,     16'hBFF0, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   0,      0,      16'hFFFF, 1, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   32767,  32767,  16'h2000, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   -32768, -32768, 16'hE000, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   12345,  -23456, 16'hC000, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   -32768, 0,      16'h8000, 0, '{0, 0, 0, 0}},
        '{FUNC_INV_PARK,   5,      -5,     16'h3FFF, 0, '{0, 0, 0, 0}}
    };

    logic clk;
    logic rst_n;

    cpt_req_if req_ch ();
    cpt_rsp_if rsp_ch ();

    clarke_park_transform_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    longint     quarter_sine [TABLE_LAST + 1];
    xform_res_t results_due [$];
    int         mismatch_count = 0;
    int         src_idle_pct   = SRC_IDLE[0];
    int         snk_idle_pct   = SNK_IDLE[0];
    int         cycle_count    = 0;

    function automatic longint q30_product(input longint x, input longint y);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned m;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        m  = (mx * my + (64'd1 << 29)) >> 30;
        return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sine_at(input angle_t ang);
        int     idx;
        longint m;
        idx = int'(ang[13:0] >> (14 - SINE_TABLE_BITS));
        m   = ang[14] ? quarter_sine[TABLE_LAST - idx] : quarter_sine[idx];
        return ang[15] ? -m : m;
    endfunction

    function automatic longint round_q15(input longint v);
        return (v + HALF_Q15) >>> 15;
    endfunction

    function automatic data_t clamp_q15(input longint v, inout logic sat);
        if (v > Q15_MAX)
        begin
            sat = 1'b1;
            return data_t'(Q15_MAX);
        end
        if (v < Q15_MIN)
        begin
            sat = 1'b1;
            return data_t'(Q15_MIN);
        end
        return data_t'(v);
    endfunction

    function automatic xform_res_t transform_of(input xform_req_t w);
        longint     a;
        longint     b;
        longint     s;
        longint     c;
        logic       sat;
        xform_res_t r;
        a   = w.a;
        b   = w.b;
        s   = sine_at(w.angle);
        c   = sine_at(angle_t'(w.angle + 16'h4000));
        sat = 1'b0;
        r   = '0;
        case (w.func)
            FUNC_CLARKE:
            begin
                r.a = clamp_q15(a, sat);
                r.b = clamp_q15(round_q15((a + 2 * b) * INV_SQRT3_Q15), sat);
            end
            FUNC_INV_CLARKE:
            begin
                r.a = clamp_q15(a, sat);
                r.b = clamp_q15(round_q15(-HALF_Q15 * a + HALF_SQRT3_Q15 * b), sat);
                r.c = clamp_q15(round_q15(-HALF_Q15 * a - HALF_SQRT3_Q15 * b), sat);
            end
            FUNC_PARK:
            begin
                r.a = clamp_q15(round_q15(a * c + b * s), sat);
                r.b = clamp_q15(round_q15(-a * s + b * c), sat);
            end
            default:
            begin
                r.a = clamp_q15(round_q15(a * c - b * s), sat);
                r.b = clamp_q15(round_q15(a * s + b * c), sat);
            end
        endcase
        r.sat = sat;
        return r;
    endfunction

    function automatic data_t pick_operand();
        case ($urandom_range(0, 7))
            0:       return data_t'(Q15_MAX);
            1:       return data_t'(Q15_MIN);
            2:       return data_t'(int'($urandom_range(0, 64)) - 32);
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic xform_req_t random_word();
        xform_req_t w;
        w       = '0;
        w.func  = func_t'($urandom_range(0, 3));
        w.a     = pick_operand();
        w.b     = pick_operand();
        if ($urandom_range(0, 7) == 0)
        begin
            w.angle = {2'($urandom_range(0, 3)), 14'h0000};
        end
        else
        begin
            w.angle = angle_t'($urandom);
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 100)
        begin
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic send_word(input xform_req_t w);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= w.func;
        req_ch.in_a  <= w.a;
        req_ch.in_b  <= w.b;
        req_ch.angle <= w.angle;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        results_due.push_back(w.known ? w.fixed : transform_of(w));
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : sine_fill
        longint x;
        longint u;
        longint p;
        longint s;
        longint e;
        for (int i = 0; i <= TABLE_LAST; i++)
        begin
            x = longint'(i) << (30 - SINE_TABLE_BITS);
            u = q30_product(x, x);
            p = TAYLOR_Q30[5];
            for (int k = 4; k >= 0; k--)
            begin
                p = TAYLOR_Q30[k] - q30_product(u, p);
            end
            s = q30_product(x, p);
            if (s < 0)
            begin
                s = 0;
            end
            e = (s * Q15_MAX + (longint'(1) << 29)) >>> 30;
            if (e > Q15_MAX)
            begin
                e = Q15_MAX;
            end
            quarter_sine[i] = e;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : result_check
        xform_res_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch("unexpected word, out_a", longint'(rsp_ch.out_a), 0);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.out_a !== want.a)
                    begin
                        report_mismatch("out_a", longint'(rsp_ch.out_a), longint'(want.a));
                    end
                    if (rsp_ch.out_b !== want.b)
                    begin
                        report_mismatch("out_b", longint'(rsp_ch.out_b), longint'(want.b));
                    end
                    if (rsp_ch.out_c !== want.c)
                    begin
                        report_mismatch("out_c", longint'(rsp_ch.out_c), longint'(want.c));
                    end
                    if (rsp_ch.saturated !== want.sat)
                    begin
                        report_mismatch("saturated", longint'(rsp_ch.saturated),
                                        longint'(want.sat));
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_CLARKE;
        req_ch.in_a  <= '0;
        req_ch.in_b  <= '0;
        req_ch.angle <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_word(DIRECTED[i]);
        end
        hold_until_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = SRC_IDLE[ph];
            snk_idle_pct = SNK_IDLE[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // sender holds off mid-stream until the pipeline empties
                if (n == HOLD_AT)
                begin
                    hold_until_drained();
                end
                send_word(random_word());
            end
            hold_until_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && results_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
